// File: rtl/core/sha256_pkg.sv
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_word_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] initial_h(input logic [2:0] idx);
      logic [31:0] h;
      case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

endpackage

// File: rtl/core/sha256_ram.sv
module sha256_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/sha256_stream_hasher_top.sv
// SHA-256 hasher for a byte stream.
// Input channel (req_): one word per message byte; has_byte marks a real byte
// and end_of_message closes the message. An end word without a byte is
// allowed, so the empty message can be hashed.
// Result channel (rsp_): eight digest words, index 0 first, last_word on
// index 7, after each end word.
// A byte that does not fill the block is a read-modify-write of the block
// buffer word. The 64th byte of a block starts a compression: load the
// working variables from the hash word RAM, 64 rounds at one per cycle
// taking the first 16 schedule words from the 16-entry block buffer RAM and
// the rest from the schedule window, then fold the working variables into
// the hash words. An end word adds padding (and a second pass when the pad
// spills into another block), the length words, one or two compressions,
// then the digest: a setup step, then one word per cycle while the receiver
// does not stall.
// A stall on rsp_ holds the current digest word; the block takes no new word
// until the digest is fully delivered.
// Reset (synchronous, active high) runs a pass loading the initial hash
// values; req_stall stays high during it. After each digest the block
// reloads the initial values itself in the same way.
module sha256_stream_hasher_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sha256_pkg::req_word_type  req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sha256_pkg::rsp_word_type  rsp_word
);
   import sha256_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_BYTE_WR, S_PAD_RD, S_PAD, S_LEN,
      S_LOADH, S_ROUND, S_FOLD, S_OUT
   } state_type;

   state_type    state_ff;
   logic [3:0]   cnt_ff;        // init/load/fold/pad/len/out index
   logic [6:0]   rnd_ff;        // round counter, one ahead of the round index for the read latency
   logic [5:0]   bib_ff;        // bytes_in_block
   logic [60:0]  total_ff;
   logic         final_ff;      // compressing the last block
   logic         second_ff;     // a further pad/length block follows
   logic [7:0]   byte_ff;
   logic         eom_ff;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [31:0]  w_ff [16];     // schedule window, w_ff[0] is w[t-16]
   rsp_word_type out_ff;
   logic         out_valid_ff;

   // block buffer RAM
   logic        bb_we;
   logic [3:0]  bb_waddr, bb_raddr;
   logic [31:0] bb_wdata, bb_rdata;
   // hash word RAM
   logic        hw_we;
   logic [2:0]  hw_waddr, hw_raddr;
   logic [31:0] hw_wdata, hw_rdata;

   sha256_ram #(.Width(32), .Depth(16)) u_block (
      .clock, .wr_en(bb_we), .wr_addr(bb_waddr), .wr_data(bb_wdata),
      .rd_addr(bb_raddr), .rd_data(bb_rdata));
   sha256_ram #(.Width(32), .Depth(8)) u_hash (
      .clock, .wr_en(hw_we), .wr_addr(hw_waddr), .wr_data(hw_wdata),
      .rd_addr(hw_raddr), .rd_data(hw_rdata));

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] merged, s0, s1, w_next, w_cur, t1, t2, wv;
   logic [1:0]  lane;
   logic [5:0]  rnd6;

   // working variable matching the hash word read last cycle
   logic [31:0] wv_prev;
   logic [31:0] wv_prev_ff;
   assign wv_prev = wv_prev_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;
   assign rnd6      = rnd_ff[5:0] - 6'd1;

   always_comb begin
      lane = bib_ff[1:0];
      // zero the lanes after the byte so the pad word needs no extra pass
      case (lane)
         2'd0: merged = {byte_ff, 24'd0};
         2'd1: merged = {bb_rdata[31:24], byte_ff, 16'd0};
         2'd2: merged = {bb_rdata[31:16], byte_ff, 8'd0};
         default: merged = {bb_rdata[31:8], byte_ff};
      endcase
      s0     = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1     = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_next = s1 + w_ff[9] + s0 + w_ff[0];
      w_cur  = (rnd_ff <= 7'd16) ? bb_rdata : w_next;
      t1 = h_ff + (rotr(e_ff, 6) ^ rotr(e_ff, 11) ^ rotr(e_ff, 25))
         + ((e_ff & f_ff) ^ (~e_ff & g_ff)) + round_k(rnd6) + w_cur;
      t2 = (rotr(a_ff, 2) ^ rotr(a_ff, 13) ^ rotr(a_ff, 22))
         + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
      case (cnt_ff[2:0])
         3'd0: wv = a_ff; 3'd1: wv = b_ff; 3'd2: wv = c_ff; 3'd3: wv = d_ff;
         3'd4: wv = e_ff; 3'd5: wv = f_ff; 3'd6: wv = g_ff; default: wv = h_ff;
      endcase
   end

   // RAM port control
   always_comb begin
      bb_we = 1'b0; bb_waddr = bib_ff[5:2]; bb_wdata = merged;
      bb_raddr = bib_ff[5:2];
      hw_we = 1'b0; hw_waddr = cnt_ff[2:0]; hw_wdata = initial_h(cnt_ff[2:0]);
      hw_raddr = cnt_ff[2:0];
      case (state_ff)
         S_INIT: hw_we = 1'b1;
         S_BYTE_WR: bb_we = 1'b1;
         S_PAD: begin
            bb_we    = 1'b1;
            bb_waddr = cnt_ff;
            // a message ending on a full block pads a fresh block from word 0
            if (cnt_ff == bib_ff[5:2] && (!second_ff || bib_ff == 6'd0)) begin
               bb_wdata = merged;
            end else begin
               bb_wdata = 32'd0;
            end
         end
         S_LEN: begin
            bb_we    = 1'b1;
            bb_waddr = cnt_ff[0] ? 4'd15 : 4'd14;
            bb_wdata = cnt_ff[0] ? {total_ff[28:0], 3'b000} : total_ff[60:29];
         end
         S_LOADH: bb_raddr = 4'd0;
         S_ROUND: bb_raddr = rnd_ff[3:0];
         S_FOLD: begin
            hw_we    = (cnt_ff != 4'd0);
            hw_waddr = cnt_ff[2:0] - 3'd1;
            hw_wdata = hw_rdata + wv_prev;
            hw_raddr = cnt_ff[2:0];
         end
         // read one word ahead of the one being offered
         S_OUT: hw_raddr = cnt_ff[2:0] + 3'd1
                         + ((out_valid_ff && !rsp_stall) ? 3'd1 : 3'd0);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      wv_prev_ff <= wv;
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rnd_ff       <= '0;
         bib_ff       <= '0;
         total_ff     <= '0;
         final_ff     <= 1'b0;
         second_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_INIT: begin
               if (cnt_ff == 4'd7) begin
                  cnt_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  eom_ff <= req_word.end_of_message;
                  if (req_word.has_byte) begin
                     byte_ff  <= req_word.data_byte;
                     state_ff <= S_BYTE_WR;
                  end else if (req_word.end_of_message) begin
                     byte_ff   <= PAD_BYTE;
                     second_ff <= 1'b0;
                     cnt_ff    <= bib_ff[5:2];
                     state_ff  <= S_PAD;
                  end
               end
            end
            S_BYTE_WR: begin
               bib_ff   <= bib_ff + 6'd1;
               total_ff <= total_ff + 61'd1;
               if (bib_ff == 6'd63) begin
                  final_ff <= 1'b0;
                  second_ff <= eom_ff;   // full block, then a padding block
                  cnt_ff   <= '0;
                  state_ff <= S_LOADH;
               end else if (eom_ff) begin
                  byte_ff   <= PAD_BYTE;
                  second_ff <= 1'b0;
                  state_ff  <= S_PAD_RD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_PAD_RD: begin
               // read the word holding the next position; pad goes at that position
               cnt_ff   <= bib_ff[5:2];
               state_ff <= S_PAD;
            end
            S_PAD: begin
               // first pass cycle writes the merged word read at the prior cycle
               if (cnt_ff == 4'd15) begin
                  cnt_ff <= '0;
                  if (!second_ff && bib_ff > 6'd55) begin
                     final_ff  <= 1'b0;
                     second_ff <= 1'b1;
                     state_ff  <= S_LOADH;
                  end else begin
                     state_ff <= S_LEN;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_LEN: begin
               if (cnt_ff == 4'd1) begin
                  cnt_ff   <= '0;
                  final_ff <= 1'b1;
                  state_ff <= S_LOADH;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_LOADH: begin
               // read hash words; capture in the following cycle
               case (cnt_ff)
                  4'd1: a_ff <= hw_rdata; 4'd2: b_ff <= hw_rdata;
                  4'd3: c_ff <= hw_rdata; 4'd4: d_ff <= hw_rdata;
                  4'd5: e_ff <= hw_rdata; 4'd6: f_ff <= hw_rdata;
                  4'd7: g_ff <= hw_rdata;
                  4'd8: h_ff <= hw_rdata;
                  default: ;
               endcase
               if (cnt_ff == 4'd8) begin
                  cnt_ff   <= '0;
                  rnd_ff   <= 7'd1;
                  state_ff <= S_ROUND;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_ROUND: begin
               rnd_ff <= rnd_ff + 7'd1;
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i+1];
               end
               w_ff[15] <= w_cur;
               h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
               d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
               if (rnd_ff == 7'd64) begin
                  cnt_ff   <= '0;
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               if (cnt_ff == 4'd8) begin
                  cnt_ff <= '0;
                  if (final_ff) begin
                     state_ff <= S_OUT;
                  end else if (second_ff) begin
                     // full block ended the message, or pad spilled over
                     byte_ff  <= PAD_BYTE;
                     state_ff <= S_PAD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_OUT: begin
               if (!out_valid_ff) begin
                  out_valid_ff <= 1'b1;
                  out_ff <= '{digest_word: hw_rdata, word_index: cnt_ff[2:0],
                              last_word: cnt_ff[2:0] == 3'd7};
               end else if (!rsp_stall) begin
                  if (cnt_ff == 4'd7) begin
                     out_valid_ff <= 1'b0;
                     cnt_ff    <= '0;
                     bib_ff    <= '0;
                     total_ff  <= '0;
                     final_ff  <= 1'b0;
                     second_ff <= 1'b0;
                     state_ff  <= S_INIT;
                  end else begin
                     cnt_ff <= cnt_ff + 4'd1;
                     out_ff <= '{digest_word: hw_rdata, word_index: cnt_ff[2:0] + 3'd1,
                                 last_word: cnt_ff[2:0] == 3'd6};
                  end
               end
            end
            default: state_ff <= S_INIT;
         endcase
      end
   end
endmodule

// File: bench/sha256_stream_hasher_top_tb.sv
module sha256_stream_hasher_top_tb;
   import sha256_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_DIRECTED = 10;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   sha256_stream_hasher_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   // hasher state mirrored by the bench
   logic [31:0] hash_state [8];
   logic [31:0] blk_words [16];
   logic [5:0]  blk_fill;
   logic [60:0] msg_bytes;

   rsp_word_type digest_queue [$];
   int mismatch_count = 0;
   int idle_cycles;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_rsp;
   bit stimulus_done;

   // directed rows; digest filled in only for the empty message and for "abc"
   typedef struct {
      req_word_type   word;
      bit             known;
      logic [255:0]   digest;
   } dir_row_type;
   dir_row_type dir_rows [NUM_DIRECTED];

   function automatic logic [31:0] rotr32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_blk();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = blk_words[t];
      for (int t = 16; t < 64; t++) begin
         s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int t = 0; t < 8; t++) v[t] = hash_state[t];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
         t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) hash_state[t] += v[t];
   endtask

   task automatic place_byte(logic [5:0] pos, logic [7:0] b);
      blk_words[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
   endtask

   task automatic clear_hasher();
      for (int i = 0; i < 8; i++) hash_state[i] = initial_h(i[2:0]);
      for (int i = 0; i < 16; i++) blk_words[i] = '0;
      blk_fill = '0;
      msg_bytes = '0;
   endtask

   task automatic predict_digest(req_word_type w);
      logic [63:0] bit_len;
      rsp_word_type r;
      if (w.has_byte) begin
         place_byte(blk_fill, w.data_byte);
         blk_fill = blk_fill + 6'd1;
         msg_bytes = msg_bytes + 61'd1;
         if (blk_fill == 0) compress_blk();
      end
      if (!w.end_of_message) return;
      place_byte(blk_fill, PAD_BYTE);
      for (int k = blk_fill + 1; k < 64; k++) place_byte(k[5:0], 8'h00);
      if (blk_fill > 55) begin
         compress_blk();
         for (int i = 0; i < 16; i++) blk_words[i] = '0;
      end
      bit_len = {msg_bytes, 3'b000};
      blk_words[14] = bit_len[63:32];
      blk_words[15] = bit_len[31:0];
      compress_blk();
      for (int i = 0; i < 8; i++) begin
         r.digest_word = hash_state[i];
         r.word_index = i[2:0];
         r.last_word = (i == 7);
         digest_queue.push_back(r);
      end
      clear_hasher();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accept a word: wait for the handshake, then hand it to the predictor;
   // valid stays up for the next word, wait_drain drops it
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      predict_digest(w);
   endtask

   task automatic send_message(int len);
      req_word_type w;
      for (int i = 0; i < len; i++) begin
         w.data_byte = 8'($urandom_range(255));
         w.has_byte = 1'b1;
         w.end_of_message = (i == len - 1) && $urandom_range(1);
         if (($urandom_range(15)) == 0) begin
            // no-byte word without end: ignored, drop in as noise
            send_word('{data_byte: 8'($urandom_range(255)), has_byte: 1'b0,
                        end_of_message: 1'b0});
         end
         send_word(w);
         if (w.end_of_message) return;
      end
      send_word('{data_byte: 8'($urandom_range(255)), has_byte: 1'b0,
                  end_of_message: 1'b1});
   endtask

   task automatic wait_drain();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (digest_queue.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
   endtask

   // result side: stall, compare
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected digest word %h", rsp_word);
            end else begin
               exp_w = digest_queue.pop_front();
               if (rsp_word !== exp_w) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("digest word mismatch: exp %h/%0d/%b got %h/%0d/%b",
                        exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                        rsp_word.digest_word, rsp_word.word_index, rsp_word.last_word);
               end
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_rsp)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   initial begin
      hold_rsp = 1'b0;
      wait (stimulus_done == 1'b0 && send_idle_pct == 0 && !reset);
      repeat (400) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (600) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int expected_before;
      int known_mismatch;
      known_mismatch = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stimulus_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      clear_hasher();

      dir_rows[0] = '{'{8'h00, 1'b0, 1'b1}, 1'b1,
         256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855};
      dir_rows[1] = '{'{8'h5a, 1'b0, 1'b0}, 1'b0, '0};
      dir_rows[2] = '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0};
      dir_rows[3] = '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0};
      dir_rows[4] = '{'{8'h63, 1'b1, 1'b1}, 1'b1,
         256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad};
      dir_rows[5] = '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0};
      dir_rows[6] = '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0};
      dir_rows[7] = '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0};
      dir_rows[8] = '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0};
      dir_rows[9] = '{'{8'h00, 1'b0, 1'b1}, 1'b0, '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         expected_before = digest_queue.size();
         send_word(dir_rows[i].word);
         if (dir_rows[i].known)
            for (int j = 0; j < 8; j++)
               if (digest_queue[expected_before + j].digest_word !==
                   dir_rows[i].digest[255 - 32 * j -: 32]) begin
                  known_mismatch++;
                  if (known_mismatch <= 10)
                     $display("known digest word %0d: exp %h got %h", j,
                        dir_rows[i].digest[255 - 32 * j -: 32],
                        digest_queue[expected_before + j].digest_word);
               end
      end
      // block edges: pad spills at 56 bytes, message ends on a full block at 64
      send_message(56);
      send_message(64);
      wait_drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         for (int m = 0; m < 2; m++) begin
            if ($urandom_range(7) == 0) send_message($urandom_range(56, 70));
            else send_message($urandom_range(0, 10));
         end
         // pause until every digest has come
         wait_drain();
      end
      stimulus_done = 1'b1;
      wait_drain();
      if (mismatch_count == 0 && known_mismatch == 0 && digest_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sha256_stream_hasher_top.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_ram.sv
rtl/core/sha256_stream_hasher_top.sv
bench/sha256_stream_hasher_top_tb.sv
